/* hdl/tpt_pkg.sv */
// shared types, constants and microcode encoding for the twin prime pair test
package tpt_pkg;

    // width of the candidate as the block sees it
    localparam int VALUE_BITS = 31;
    // working value width: holds n + 2 without wrap
    localparam int VAL_W = VALUE_BITS + 1;
    // trial divisor width: covers the square root of the value plus one
    localparam int D_W = (VAL_W + 1) / 2 + 1;
    // divider bit counter width
    localparam int CNT_W = $clog2(VAL_W);

    // microcode program geometry
    localparam int STEP_W = 4;

    typedef logic [STEP_W-1:0] tpt_step_t;

    // program addresses
    localparam tpt_step_t STEP_IDLE     = 4'd0;
    localparam tpt_step_t STEP_SETUP    = 4'd1;
    localparam tpt_step_t STEP_DIV_GO   = 4'd2;
    localparam tpt_step_t STEP_DIV_WAIT = 4'd3;
    localparam tpt_step_t STEP_BOUND    = 4'd4;
    localparam tpt_step_t STEP_REM      = 4'd5;
    localparam tpt_step_t STEP_COMP     = 4'd6;
    localparam tpt_step_t STEP_PRIME    = 4'd7;
    localparam tpt_step_t STEP_NEXT     = 4'd8;
    localparam tpt_step_t STEP_HOLD     = 4'd9;
    localparam tpt_step_t STEP_FINISH   = 4'd10;

    // datapath actions
    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_LOAD_LOW,
        ACT_INIT_D,
        ACT_DIV_GO,
        ACT_INC_D,
        ACT_REC_COMP,
        ACT_REC_PRIME,
        ACT_LOAD_HIGH,
        ACT_DONE
    } tpt_act_t;

    // jump conditions: jump to target when true, else fall through
    typedef enum logic [3:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_START,
        COND_SMALL,
        COND_DIV_BUSY,
        COND_BOUND,
        COND_REM_NZ,
        COND_LOW_PASS,
        COND_OUT_FULL
    } tpt_cond_t;

    // one control word
    typedef struct packed {
        tpt_act_t  act;
        tpt_cond_t cond;
        tpt_step_t target;
    } tpt_uword_t;

    // control from the top level into the sequencer
    typedef struct packed {
        logic start;
        logic out_free;
    } tpt_ctl_t;

    // status and result from the sequencer
    typedef struct packed {
        logic idle;
        logic done;
        logic low_prime;
        logic high_prime;
    } tpt_res_t;

endpackage

/* hdl/tpt_urom.sv */
// microcode read-only table of the trial division sequencer
module tpt_urom
    import tpt_pkg::*;
(
    input  tpt_step_t  step,
    output tpt_uword_t uword
);

    // one control word per program step
    always_comb begin
        case (step)
            STEP_IDLE:     uword = '{ACT_LOAD_LOW,  COND_NO_START, STEP_IDLE};
            STEP_SETUP:    uword = '{ACT_INIT_D,    COND_SMALL,    STEP_COMP};
            STEP_DIV_GO:   uword = '{ACT_DIV_GO,    COND_NONE,     STEP_IDLE};
            STEP_DIV_WAIT: uword = '{ACT_NOP,       COND_DIV_BUSY, STEP_DIV_WAIT};
            STEP_BOUND:    uword = '{ACT_NOP,       COND_BOUND,    STEP_PRIME};
            STEP_REM:      uword = '{ACT_INC_D,     COND_REM_NZ,   STEP_DIV_GO};
            STEP_COMP:     uword = '{ACT_REC_COMP,  COND_ALWAYS,   STEP_NEXT};
            STEP_PRIME:    uword = '{ACT_REC_PRIME, COND_NONE,     STEP_IDLE};
            STEP_NEXT:     uword = '{ACT_LOAD_HIGH, COND_LOW_PASS, STEP_SETUP};
            STEP_HOLD:     uword = '{ACT_NOP,       COND_OUT_FULL, STEP_HOLD};
            STEP_FINISH:   uword = '{ACT_DONE,      COND_ALWAYS,   STEP_IDLE};
            default:       uword = '{ACT_NOP,       COND_ALWAYS,   STEP_IDLE};
        endcase
    end

endmodule

/* hdl/tpt_div.sv */
// restoring divider, one quotient bit per cycle
module tpt_div
    import tpt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             go,
    input  logic [VAL_W-1:0] dividend,
    input  logic [D_W-1:0]   divisor,
    output logic             busy,
    output logic [VAL_W-1:0] quo,
    output logic [D_W-1:0]   rem
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   dsr_reg, dsr_next;
    logic [D_W:0]     trial;
    logic             fits;

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[VAL_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (go) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VAL_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VAL_W-2:0], fits};
            rem_next = fits ? D_W'(trial - {1'b0, dsr_reg}) : trial[D_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

/* hdl/tpt_seq.sv */
// microcoded sequencer and trial division datapath
module tpt_seq
    import tpt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [VALUE_BITS-1:0] candidate,
    input  tpt_ctl_t              ctl,
    output tpt_res_t              res
);

    tpt_step_t        step_reg, step_next;
    logic [VAL_W-1:0] v_reg, v_next;
    logic [D_W-1:0]   d_reg, d_next;
    logic             which_reg, which_next;
    logic             lo_reg, lo_next;
    logic             hi_reg, hi_next;
    tpt_uword_t       uword;
    logic             cond_true;
    logic             div_busy;
    logic [VAL_W-1:0] div_quo;
    logic [D_W-1:0]   div_rem;

    // control store
    tpt_urom u_urom (
        .step  (step_reg),
        .uword (uword)
    );

    // shared divider
    tpt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (uword.act == ACT_DIV_GO),
        .dividend (v_reg),
        .divisor  (d_reg),
        .busy     (div_busy),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // condition select
    always_comb begin
        case (uword.cond)
            COND_NONE:     cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_NO_START: cond_true = !ctl.start;
            COND_SMALL:    cond_true = (v_reg[VAL_W-1:1] == '0);
            COND_DIV_BUSY: cond_true = div_busy;
            COND_BOUND:    cond_true = VAL_W'(d_reg) > div_quo;
            COND_REM_NZ:   cond_true = (div_rem != '0);
            COND_LOW_PASS: cond_true = !which_reg;
            COND_OUT_FULL: cond_true = !ctl.out_free;
            default:       cond_true = 1'b1;
        endcase
    end

    // next step and datapath actions
    always_comb begin
        step_next  = cond_true ? uword.target : step_reg + 1'b1;
        v_next     = v_reg;
        d_next     = d_reg;
        which_next = which_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        case (uword.act)
            ACT_LOAD_LOW: begin
                v_next     = VAL_W'(candidate);
                which_next = 1'b0;
            end
            ACT_INIT_D: begin
                d_next = D_W'(2);
            end
            ACT_INC_D: begin
                d_next = d_reg + 1'b1;
            end
            ACT_REC_COMP: begin
                if (which_reg) begin
                    hi_next = 1'b0;
                end else begin
                    lo_next = 1'b0;
                end
            end
            ACT_REC_PRIME: begin
                if (which_reg) begin
                    hi_next = 1'b1;
                end else begin
                    lo_next = 1'b1;
                end
            end
            ACT_LOAD_HIGH: begin
                v_next     = VAL_W'(candidate) + VAL_W'(2);
                which_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
        v_reg     <= v_next;
        d_reg     <= d_next;
        which_reg <= which_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
    end

    assign res.idle       = (step_reg == STEP_IDLE);
    assign res.done       = (uword.act == ACT_DONE);
    assign res.low_prime  = lo_reg;
    assign res.high_prime = hi_reg;

endmodule

/* hdl/twin_prime_pair_test.sv */
// twin prime pair test: trial division of n and n + 2 under microcode control
// each trial divisor runs through the bit-serial divider, with program steps around it
// one transaction at a time; a new candidate is taken once the result of the
//   previous one is in the output register
// reset: synchronous active-low aresetn clears the step counter and handshake state
module twin_prime_pair_test
    import tpt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_candidate,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_low_is_prime,
    output logic                  m_high_is_prime,
    output logic                  m_is_twin_pair
);

    logic                  busy_reg, busy_next;
    logic                  start_reg, start_next;
    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_BITS-1:0] cand_reg, cand_next;
    logic                  lo_reg, lo_next;
    logic                  hi_reg, hi_next;
    logic                  in_acc;
    tpt_ctl_t              seq_ctl;
    tpt_res_t              seq_res;

    assign in_acc = s_valid && s_ready;

    // sequencer
    assign seq_ctl.start    = start_reg;
    assign seq_ctl.out_free = !m_valid_reg || m_ready;

    tpt_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .candidate (cand_reg),
        .ctl       (seq_ctl),
        .res       (seq_res)
    );

    // input capture and output register
    always_comb begin
        busy_next    = busy_reg;
        start_next   = 1'b0;
        m_valid_next = m_valid_reg;
        cand_next    = cand_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (in_acc) begin
            busy_next  = 1'b1;
            start_next = 1'b1;
            cand_next  = s_candidate;
        end
        if (seq_res.done) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            lo_next      = seq_res.low_prime;
            hi_next      = seq_res.high_prime;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        cand_reg <= cand_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
    end

    assign s_ready         = !busy_reg;
    assign m_valid         = m_valid_reg;
    assign m_low_is_prime  = lo_reg;
    assign m_high_is_prime = hi_reg;
    assign m_is_twin_pair  = lo_reg && hi_reg;

    // ready only while the program waits at its entry step
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> seq_res.idle)
        else $error("input ready while sequencer is running");

    // an accepted transaction blocks the next one
    a_acc_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("input ready right after a transaction");

    // a result is only produced when the output register can take it
    a_done_free: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_res.done |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending transaction");

    // completion always follows a start and never comes while idle
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_res.done |-> busy_reg)
        else $error("result produced with no transaction in flight");

endmodule
